// ----- rtl/wav_hdr_pkg.sv -----
package wav_hdr_pkg;

  localparam int HEADER_BYTES = 44;
  localparam int POS_W = $clog2(HEADER_BYTES + 1);
  localparam int OUT_BITS = 1 + 4 + 16 + 32 + 16 + 32;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [3:0] {
    FLT_NONE     = 4'd0,
    FLT_SHORT    = 4'd1,
    FLT_RIFF     = 4'd2,
    FLT_WAVE     = 4'd3,
    FLT_FMT_TAG  = 4'd4,
    FLT_FMT_SIZE = 4'd5,
    FLT_FORMAT   = 4'd6,
    FLT_DATA_TAG = 4'd7,
    FLT_CHANNELS = 4'd8,
    FLT_BITS     = 4'd9,
    FLT_EMPTY    = 4'd10,
    FLT_ALIGN    = 4'd11
  } fault_t;

  // Tags, first byte in the low bits
  localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
  localparam logic [31:0] WAVE_TAG = 32'h4556_4157;
  localparam logic [31:0] FMT_TAG  = 32'h2074_6D66;
  localparam logic [31:0] DATA_TAG = 32'h6174_6164;

  localparam logic [7:0] FMT_SIZE_LOW = 8'd16;
  localparam logic [7:0] PCM_FORMAT   = 8'd1;
  localparam logic [15:0] PCM_BITS    = 16'd16;

  function automatic logic [7:0] tag_byte(logic [31:0] tag, logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = tag[7:0];
      2'd1:    b = tag[15:8];
      2'd2:    b = tag[23:16];
      default: b = tag[31:24];
    endcase
    return b;
  endfunction

  // Structural fault raised by byte b at position p; tags start on 4-byte bounds
  function automatic fault_t struct_fault(pos_t p, logic [7:0] b);
    fault_t f;
    f = FLT_NONE;
    if (p < pos_t'(4)) begin
      if (b != tag_byte(RIFF_TAG, p[1:0])) f = FLT_RIFF;
    end else if (p >= pos_t'(8) && p < pos_t'(12)) begin
      if (b != tag_byte(WAVE_TAG, p[1:0])) f = FLT_WAVE;
    end else if (p >= pos_t'(12) && p < pos_t'(16)) begin
      if (b != tag_byte(FMT_TAG, p[1:0])) f = FLT_FMT_TAG;
    end else if (p == pos_t'(16)) begin
      if (b != FMT_SIZE_LOW) f = FLT_FMT_SIZE;
    end else if (p > pos_t'(16) && p < pos_t'(20)) begin
      if (b != 8'd0) f = FLT_FMT_SIZE;
    end else if (p == pos_t'(20)) begin
      if (b != PCM_FORMAT) f = FLT_FORMAT;
    end else if (p == pos_t'(21)) begin
      if (b != 8'd0) f = FLT_FORMAT;
    end else if (p >= pos_t'(36) && p < pos_t'(40)) begin
      if (b != tag_byte(DATA_TAG, p[1:0])) f = FLT_DATA_TAG;
    end
    return f;
  endfunction

endpackage

// ----- rtl/wav_header_parser.sv -----
// WAV header checker for a canonical 44-byte RIFF/WAVE PCM header.
// Input stream: one header byte per request on in_tdata, in_tlast on the
// final byte of a header. Bytes after the 44th are ignored until in_tlast.
// Result stream: one request per header, issued for the byte marked last,
// carrying pass flag, fault code and the captured channel count, sample rate,
// bits per sample and data length (fields are zero on a short or structural
// fault). The sample rate is passed out for an external support check.
// Latency: the result is valid the cycle after the last byte is taken.
// Throughput: one byte per cycle while in_tready is high. Fields are captured
// per byte; the byte-rate product (rate times block align) runs on one
// registered 32x16 multiplier that is ready long before byte 44 arrives.
// After a verdict all state clears for the next header.
// Reset (rst_n low, synchronous) clears the byte position, fault and
// captured fields and empties the result register.
// A stalled receiver holds the result; a new byte is still taken as long as
// it does not itself produce a result, else in_tready drops until the
// waiting result is taken.
module wav_header_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,  // [7:0] header_byte
  input  logic                                in_tlast,  // last_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] header_ok, [4:1] fault_code, [20:5] channel_count, [52:21] rate_hz,
  // [68:53] sample_width, [100:69] data_length, [103:101] zero
  output logic [wav_hdr_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import wav_hdr_pkg::*;

  pos_t        pos_r, pos_nxt;
  fault_t      fault_r, fault_nxt, byte_fault, code;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] brate_r, brate_nxt;
  logic [15:0] align_r, align_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] payload_r, payload_nxt;
  logic [31:0] mult_full;
  logic [31:0] prod_r;
  logic        fields_shown;
  logic        in_fire, verdict;
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] result;

  assign in_tready = !out_tvalid_r || !in_tlast || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign verdict   = in_fire && in_tlast;

  // Byte rate is compared modulo 2^32
  assign mult_full = rate_r * {16'd0, align_r};

  always_comb begin
    pos_nxt     = pos_r;
    fault_nxt   = fault_r;
    chan_nxt    = chan_r;
    rate_nxt    = rate_r;
    brate_nxt   = brate_r;
    align_nxt   = align_r;
    bits_nxt    = bits_r;
    payload_nxt = payload_r;
    byte_fault  = struct_fault(pos_r, in_tdata);
    if (pos_r < pos_t'(HEADER_BYTES)) begin
      pos_nxt = pos_r + pos_t'(1);
      if (fault_r == FLT_NONE) fault_nxt = byte_fault;
      if (pos_r >= pos_t'(22) && pos_r < pos_t'(24)) begin
        chan_nxt[8*pos_r[0] +: 8] = in_tdata;
      end else if (pos_r >= pos_t'(24) && pos_r < pos_t'(28)) begin
        rate_nxt[8*pos_r[1:0] +: 8] = in_tdata;
      end else if (pos_r >= pos_t'(28) && pos_r < pos_t'(32)) begin
        brate_nxt[8*pos_r[1:0] +: 8] = in_tdata;
      end else if (pos_r >= pos_t'(32) && pos_r < pos_t'(34)) begin
        align_nxt[8*pos_r[0] +: 8] = in_tdata;
      end else if (pos_r >= pos_t'(34) && pos_r < pos_t'(36)) begin
        bits_nxt[8*pos_r[0] +: 8] = in_tdata;
      end else if (pos_r >= pos_t'(40) && pos_r < pos_t'(44)) begin
        payload_nxt[8*pos_r[1:0] +: 8] = in_tdata;
      end
    end
  end

  // Verdict on the updated state; prod_r is settled since align and rate
  // are complete ten bytes before the header ends
  always_comb begin
    fields_shown = 1'b0;
    if (pos_nxt < pos_t'(HEADER_BYTES)) begin
      code = FLT_SHORT;
    end else if (fault_nxt != FLT_NONE) begin
      code = fault_nxt;
    end else begin
      fields_shown = 1'b1;
      if (chan_nxt != 16'd1 && chan_nxt != 16'd2) begin
        code = FLT_CHANNELS;
      end else if (bits_nxt != PCM_BITS) begin
        code = FLT_BITS;
      end else if (payload_nxt == 32'd0) begin
        code = FLT_EMPTY;
      end else if ({1'b0, align_nxt} != {chan_nxt, 1'b0} || brate_nxt != prod_r) begin
        code = FLT_ALIGN;
      end else begin
        code = FLT_NONE;
      end
    end
    result = '0;
    result[0]   = (code == FLT_NONE);
    result[4:1] = code;
    if (fields_shown) begin
      result[20:5]   = chan_nxt;
      result[52:21]  = rate_nxt;
      result[68:53]  = bits_nxt;
      result[100:69] = payload_nxt;
    end
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_tready) out_tvalid_nxt = 1'b0;
    if (verdict) out_tvalid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      fault_r      <= FLT_NONE;
      chan_r       <= '0;
      rate_r       <= '0;
      brate_r      <= '0;
      align_r      <= '0;
      bits_r       <= '0;
      payload_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
      if (verdict) begin
        // clear for the next header
        pos_r     <= '0;
        fault_r   <= FLT_NONE;
        chan_r    <= '0;
        rate_r    <= '0;
        brate_r   <= '0;
        align_r   <= '0;
        bits_r    <= '0;
        payload_r <= '0;
      end else if (in_fire) begin
        pos_r     <= pos_nxt;
        fault_r   <= fault_nxt;
        chan_r    <= chan_nxt;
        rate_r    <= rate_nxt;
        brate_r   <= brate_nxt;
        align_r   <= align_nxt;
        bits_r    <= bits_nxt;
        payload_r <= payload_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mult_full;
    if (verdict) out_data_r <= result;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= pos_t'(HEADER_BYTES))
    else $error("byte position past header length");

  a_verdict_clears: assert property (@(posedge clk) disable iff (!rst_n)
    verdict |=> (out_tvalid && pos_r == '0 && fault_r == FLT_NONE))
    else $error("verdict did not issue result and clear state");

  a_ok_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[4:1] == FLT_NONE)))
    else $error("pass flag disagrees with fault code");

  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[4:1] != FLT_NONE && out_tdata[4:1] < FLT_CHANNELS)
      |-> out_tdata[100:5] == '0)
    else $error("fields shown on short or structural fault");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready && in_tvalid && in_tlast) |-> !in_tready)
    else $error("waiting result could be overwritten");

endmodule
